// ===== rtl/sds_pkg.sv =====
`timescale 1ns / 1ps

package sds_pkg;

    // Fixed field widths of the item and result transactions.
    localparam int CARD_W   = 6;
    localparam int CNT_W    = 7;
    localparam int WORD_W   = 15;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;
    localparam int RMAX_W   = 31;
    localparam int MCNT_W   = 4;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_REFILL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHUFFLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORD    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DEAL    = 2'd3;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_REJECTED = 3'd1,
        ST_FINISHED = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_IGNORED  = 3'd4
    } status_t;

    // Which deck position feeds the store address.
    typedef enum logic [1:0] {
        SEL_CUR,
        SEL_RAND,
        SEL_DEAL
    } addr_sel_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MOD,
        S_RD_A,
        S_RD_B,
        S_WR_A,
        S_WR_B,
        S_DEAL_RD,
        S_DEAL_OUT,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_item;
        logic      refill;
        logic      arm;
        logic      mod_start;
        logic      mod_step;
        addr_sel_t addr_sel;
        logic      rd_en;
        logic      wr_en;
        logic      wr_src_a;
        logic      latch_a;
        logic      step_done;
        logic      deal_start;
        logic      emit_card;
        logic      emit_single;
        status_t   emit_status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              shuffling;
        logic              left_le1;
        logic              left_zero;
        logic              actual_zero;
        logic              rejected;
        logic              mod_last;
        logic              cursor_one;
        logic              deal_last;
        logic              out_free;
    } dp_status_t;

endpackage

// ===== rtl/sds_ram.sv =====
`timescale 1ns / 1ps

module sds_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 52
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sds_ctrl.sv =====
`timescale 1ns / 1ps

module sds_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  sds_pkg::dp_status_t stat,
    output sds_pkg::cmd_t      cmd
);

    sds_pkg::state_t  state_reg;
    sds_pkg::state_t  state_next;
    sds_pkg::status_t code_reg;
    sds_pkg::status_t code_next;

    // State and pending status code registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sds_pkg::S_IDLE;
            code_reg  <= sds_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next      = state_reg;
        code_next       = code_reg;
        cmd             = '0;
        cmd.addr_sel    = sds_pkg::SEL_CUR;
        cmd.emit_status = code_reg;
        cmd_stall       = 1'b1;

        case (state_reg)
            sds_pkg::S_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = sds_pkg::S_DISPATCH;
                end
            end

            sds_pkg::S_DISPATCH:
            begin
                state_next = sds_pkg::S_EMIT;
                code_next  = sds_pkg::ST_OK;
                case (stat.mode)
                    sds_pkg::MODE_REFILL:
                    begin
                        cmd.refill = 1'b1;
                    end
                    sds_pkg::MODE_SHUFFLE:
                    begin
                        if (stat.shuffling)
                        begin
                            code_next = sds_pkg::ST_IGNORED;
                        end
                        else if (stat.left_le1)
                        begin
                            code_next = sds_pkg::ST_FINISHED;
                        end
                        else
                        begin
                            cmd.arm = 1'b1;
                        end
                    end
                    sds_pkg::MODE_WORD:
                    begin
                        if (!stat.shuffling)
                        begin
                            code_next = sds_pkg::ST_IGNORED;
                        end
                        else if (stat.rejected)
                        begin
                            code_next = sds_pkg::ST_REJECTED;
                        end
                        else
                        begin
                            cmd.mod_start = 1'b1;
                            state_next    = sds_pkg::S_MOD;
                        end
                    end
                    default:
                    begin
                        if (stat.shuffling)
                        begin
                            code_next = sds_pkg::ST_IGNORED;
                        end
                        else if (stat.left_zero)
                        begin
                            code_next = sds_pkg::ST_EMPTY;
                        end
                        else if (!stat.actual_zero)
                        begin
                            cmd.deal_start = 1'b1;
                            state_next     = sds_pkg::S_DEAL_RD;
                        end
                    end
                endcase
            end

            // One remainder bit per cycle.
            sds_pkg::S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                begin
                    state_next = sds_pkg::S_RD_A;
                end
            end

            sds_pkg::S_RD_A:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = sds_pkg::SEL_CUR;
                state_next   = sds_pkg::S_RD_B;
            end

            sds_pkg::S_RD_B:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = sds_pkg::SEL_RAND;
                cmd.latch_a  = 1'b1;
                state_next   = sds_pkg::S_WR_A;
            end

            sds_pkg::S_WR_A:
            begin
                cmd.wr_en    = 1'b1;
                cmd.addr_sel = sds_pkg::SEL_CUR;
                state_next   = sds_pkg::S_WR_B;
            end

            sds_pkg::S_WR_B:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_src_a  = 1'b1;
                cmd.addr_sel  = sds_pkg::SEL_RAND;
                cmd.step_done = 1'b1;
                code_next     = stat.cursor_one ? sds_pkg::ST_FINISHED : sds_pkg::ST_OK;
                state_next    = sds_pkg::S_EMIT;
            end

            sds_pkg::S_DEAL_RD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = sds_pkg::SEL_DEAL;
                state_next   = sds_pkg::S_DEAL_OUT;
            end

            sds_pkg::S_DEAL_OUT:
            begin
                cmd.addr_sel = sds_pkg::SEL_DEAL;
                if (stat.out_free)
                begin
                    cmd.emit_card = 1'b1;
                    state_next    = stat.deal_last ? sds_pkg::S_IDLE : sds_pkg::S_DEAL_RD;
                end
            end

            sds_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_single = 1'b1;
                    state_next      = sds_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sds_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sds_datapath.sv =====
`timescale 1ns / 1ps

module sds_datapath #(
    parameter int DECK_CARDS = 52,
    parameter int unsigned RANDOM_MAX = 32767
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [sds_pkg::MODE_W-1:0]      mode,
    input  logic [sds_pkg::WORD_W-1:0]      random_word,
    input  logic [sds_pkg::CNT_W-1:0]       deal_count,
    input  sds_pkg::cmd_t                   cmd,
    output sds_pkg::dp_status_t             stat,
    output logic [sds_pkg::CARD_W-1:0]      card,
    output logic                            card_valid,
    output logic                            last,
    output logic [sds_pkg::STATUS_W-1:0]    status,
    output logic [sds_pkg::CNT_W-1:0]       remaining,
    output logic [sds_pkg::CNT_W-1:0]       dealt_total,
    output logic                            res_valid,
    input  logic                            res_stall
);

    localparam int AW = (DECK_CARDS > 1) ? $clog2(DECK_CARDS) : 1;
    localparam int HW = sds_pkg::CNT_W + 1;

    // Item registers.
    logic [sds_pkg::MODE_W-1:0] mode_reg;
    logic [sds_pkg::WORD_W-1:0] word_reg;
    logic [sds_pkg::CNT_W-1:0]  want_reg;

    // Deck state.
    logic [AW-1:0]             head_reg;
    logic [AW-1:0]             head_next;
    logic [sds_pkg::CNT_W-1:0] left_reg;
    logic [sds_pkg::CNT_W-1:0] left_next;
    logic [AW-1:0]             cursor_reg;
    logic [AW-1:0]             cursor_next;
    logic                      shuf_reg;
    logic                      shuf_next;
    logic [DECK_CARDS-1:0]     vld_reg;

    // Remainder unit.
    logic [sds_pkg::CNT_W-1:0]  rem_reg;
    logic [sds_pkg::WORD_W-1:0] shift_reg;
    logic [sds_pkg::MCNT_W-1:0] mcnt_reg;
    logic [sds_pkg::CNT_W-1:0]  bound;
    logic [sds_pkg::CNT_W:0]    trial;
    logic [sds_pkg::CNT_W-1:0]  rem_step;

    // Swap and deal registers.
    logic [sds_pkg::CARD_W-1:0] vala_reg;
    logic [sds_pkg::CNT_W-1:0]  actual_reg;
    logic [sds_pkg::CNT_W-1:0]  actual;
    logic [sds_pkg::CNT_W-1:0]  k_reg;

    // Store access.
    logic [AW-1:0]              pos;
    logic [AW:0]                slot_sum;
    logic [AW-1:0]              slot_addr;
    logic [sds_pkg::CARD_W-1:0] ram_q;
    logic [sds_pkg::CARD_W-1:0] rd_card;
    logic [sds_pkg::CARD_W-1:0] wr_data;
    logic                       rvld_reg;
    logic [AW-1:0]              raddr_reg;
    logic [HW-1:0]              head_sum;

    // Rejection limits, one per cursor value, fixed at elaboration.
    logic [sds_pkg::RMAX_W-1:0] lim_tab [DECK_CARDS];
    logic                       rejected;

    // Output register.
    logic [sds_pkg::CARD_W-1:0] card_reg;
    logic                       card_valid_reg;
    logic                       last_reg;
    sds_pkg::status_t           status_reg;
    logic [sds_pkg::CNT_W-1:0]  remaining_reg;
    logic [sds_pkg::CNT_W-1:0]  dealt_reg;
    logic                       res_valid_reg;
    logic                       out_free;

    for (genvar k = 0; k < DECK_CARDS; k++)
    begin : g_lim
        localparam longint unsigned LIM = RANDOM_MAX - (RANDOM_MAX % (k + 1));
        assign lim_tab[k] = sds_pkg::RMAX_W'(LIM);
    end

    assign rejected = {{(sds_pkg::RMAX_W - sds_pkg::WORD_W){1'b0}}, word_reg}
                      >= lim_tab[cursor_reg];

    // Deck position to store address: one wrap around the ring.
    always_comb
    begin
        case (cmd.addr_sel)
            sds_pkg::SEL_CUR:  pos = cursor_reg;
            sds_pkg::SEL_RAND: pos = rem_reg[AW-1:0];
            sds_pkg::SEL_DEAL: pos = k_reg[AW-1:0];
            default:           pos = cursor_reg;
        endcase
        slot_sum = {1'b0, head_reg} + {1'b0, pos};
        if (slot_sum >= (AW + 1)'(DECK_CARDS))
        begin
            slot_addr = AW'(slot_sum - (AW + 1)'(DECK_CARDS));
        end
        else
        begin
            slot_addr = slot_sum[AW-1:0];
        end
    end

    // An entry never written since refill holds its own index.
    assign rd_card = rvld_reg ? ram_q : sds_pkg::CARD_W'(raddr_reg);
    assign wr_data = cmd.wr_src_a ? vala_reg : rd_card;

    sds_ram #(
        .WIDTH (sds_pkg::CARD_W),
        .DEPTH (DECK_CARDS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (slot_addr),
        .wdata (wr_data),
        .re    (cmd.rd_en),
        .raddr (slot_addr),
        .rdata (ram_q)
    );

    // One restoring remainder step.
    assign bound    = sds_pkg::CNT_W'(cursor_reg) + 1'b1;
    assign trial    = {rem_reg, shift_reg[sds_pkg::WORD_W-1]};
    assign rem_step = (trial >= {1'b0, bound}) ? sds_pkg::CNT_W'(trial - {1'b0, bound})
                                               : trial[sds_pkg::CNT_W-1:0];

    assign actual   = (want_reg < left_reg) ? want_reg : left_reg;
    assign head_sum = HW'(head_reg) + HW'(actual_reg);

    // Next deck state.
    always_comb
    begin
        head_next   = head_reg;
        left_next   = left_reg;
        cursor_next = cursor_reg;
        shuf_next   = shuf_reg;
        if (cmd.refill)
        begin
            head_next   = '0;
            left_next   = sds_pkg::CNT_W'(DECK_CARDS);
            cursor_next = '0;
            shuf_next   = 1'b0;
        end
        if (cmd.arm)
        begin
            cursor_next = AW'(left_reg - 1'b1);
            shuf_next   = 1'b1;
        end
        if (cmd.step_done)
        begin
            cursor_next = cursor_reg - 1'b1;
            if (cursor_reg == AW'(1))
            begin
                shuf_next = 1'b0;
            end
        end
        if (cmd.deal_start)
        begin
            left_next = left_reg - actual;
        end
        if (cmd.emit_card && stat.deal_last)
        begin
            if (head_sum >= HW'(DECK_CARDS))
            begin
                head_next = AW'(head_sum - HW'(DECK_CARDS));
            end
            else
            begin
                head_next = head_sum[AW-1:0];
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            left_reg      <= sds_pkg::CNT_W'(DECK_CARDS);
            cursor_reg    <= '0;
            shuf_reg      <= 1'b0;
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            left_reg   <= left_next;
            cursor_reg <= cursor_next;
            shuf_reg   <= shuf_next;
            if (cmd.refill)
            begin
                vld_reg <= '0;
            end
            else if (cmd.wr_en)
            begin
                vld_reg[slot_addr] <= 1'b1;
            end
            if (cmd.emit_card || cmd.emit_single)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= mode;
            word_reg <= random_word;
            want_reg <= deal_count;
        end
        if (cmd.mod_start)
        begin
            rem_reg   <= '0;
            shift_reg <= word_reg;
            mcnt_reg  <= '0;
        end
        else if (cmd.mod_step)
        begin
            rem_reg   <= rem_step;
            shift_reg <= {shift_reg[sds_pkg::WORD_W-2:0], 1'b0};
            mcnt_reg  <= mcnt_reg + 1'b1;
        end
        if (cmd.rd_en)
        begin
            rvld_reg  <= vld_reg[slot_addr];
            raddr_reg <= slot_addr;
        end
        if (cmd.latch_a)
        begin
            vala_reg <= rd_card;
        end
        if (cmd.deal_start)
        begin
            actual_reg <= actual;
            k_reg      <= '0;
        end
        else if (cmd.emit_card)
        begin
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.emit_card)
        begin
            card_reg       <= rd_card;
            card_valid_reg <= 1'b1;
            last_reg       <= stat.deal_last;
            status_reg     <= sds_pkg::ST_OK;
            remaining_reg  <= left_reg;
            dealt_reg      <= actual_reg;
        end
        else if (cmd.emit_single)
        begin
            card_reg       <= '0;
            card_valid_reg <= 1'b0;
            last_reg       <= 1'b1;
            status_reg     <= cmd.emit_status;
            remaining_reg  <= left_reg;
            dealt_reg      <= '0;
        end
    end

    assign out_free = !res_valid_reg || !res_stall;

    // Status toward the controller.
    always_comb
    begin
        stat.mode        = mode_reg;
        stat.shuffling   = shuf_reg;
        stat.left_le1    = (left_reg <= sds_pkg::CNT_W'(1));
        stat.left_zero   = (left_reg == '0);
        stat.actual_zero = (actual == '0);
        stat.rejected    = rejected;
        stat.mod_last    = (mcnt_reg == sds_pkg::MCNT_W'(sds_pkg::WORD_W - 1));
        stat.cursor_one  = (cursor_reg == AW'(1));
        stat.deal_last   = ((k_reg + 1'b1) == actual_reg);
        stat.out_free    = out_free;
    end

    assign card        = card_reg;
    assign card_valid  = card_valid_reg;
    assign last        = last_reg;
    assign status      = status_reg;
    assign remaining   = remaining_reg;
    assign dealt_total = dealt_reg;
    assign res_valid   = res_valid_reg;

endmodule

// ===== rtl/shuffled_deal_store_unit.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake             | Payload
// ---------+-----------------------+---------------------------------------------
// command  | cmd_valid, cmd_stall  | mode, random_word, deal_count
// result   | res_valid, res_stall  | card, card_valid, last, status, remaining,
//          |                       | dealt_total
//
// Every item that gives one result without a swap goes from dispatch straight to the emit state.
// An accepted random word passes through the bit-serial remainder unit, one step per word bit,
// then four store accesses for the swap, one per cycle, between dispatch and result.
// A deal reads each card with one registered memory read before the card is sent out.
// Reset gives the ordered deck at once through per-entry valid bits; no clearing pass.
// Result stalls hold the output register; a new command transaction is taken while
// the last result of the previous one still waits.

module shuffled_deal_store_unit #(
    parameter int DECK_CARDS = 52,
    parameter int unsigned RANDOM_MAX = 32767
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic [sds_pkg::MODE_W-1:0]   mode,
    input  logic [sds_pkg::WORD_W-1:0]   random_word,
    input  logic [sds_pkg::CNT_W-1:0]    deal_count,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic [sds_pkg::CARD_W-1:0]   card,
    output logic                         card_valid,
    output logic                         last,
    output logic [sds_pkg::STATUS_W-1:0] status,
    output logic [sds_pkg::CNT_W-1:0]    remaining,
    output logic [sds_pkg::CNT_W-1:0]    dealt_total
);

    sds_pkg::cmd_t       cmd;
    sds_pkg::dp_status_t stat;

    sds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    sds_datapath #(
        .DECK_CARDS (DECK_CARDS),
        .RANDOM_MAX (RANDOM_MAX)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode),
        .random_word (random_word),
        .deal_count  (deal_count),
        .cmd         (cmd),
        .stat        (stat),
        .card        (card),
        .card_valid  (card_valid),
        .last        (last),
        .status      (status),
        .remaining   (remaining),
        .dealt_total (dealt_total),
        .res_valid   (res_valid),
        .res_stall   (res_stall)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int          DECK        = 52;
    localparam int unsigned RMAX        = 32767;
    localparam int          STUCK_LIMIT = 3000;

    // One result transaction as seen on the result channel.
    typedef struct packed {
        logic [sds_pkg::CARD_W-1:0] card;
        logic                       card_valid;
        logic                       last;
        sds_pkg::status_t           status;
        logic [sds_pkg::CNT_W-1:0]  remaining;
        logic [sds_pkg::CNT_W-1:0]  dealt_total;
    } deck_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cmd_valid;
    logic                         cmd_stall;
    logic [sds_pkg::MODE_W-1:0]   mode;
    logic [sds_pkg::WORD_W-1:0]   random_word;
    logic [sds_pkg::CNT_W-1:0]    deal_count;
    logic                         res_valid;
    logic                         res_stall;
    logic [sds_pkg::CARD_W-1:0]   card;
    logic                         card_valid;
    logic                         last;
    logic [sds_pkg::STATUS_W-1:0] status;
    logic [sds_pkg::CNT_W-1:0]    remaining;
    logic [sds_pkg::CNT_W-1:0]    dealt_total;

    // Deck state as the testbench expects it to be.
    logic [sds_pkg::CARD_W-1:0] deck_cards [0:DECK-1];
    int unsigned                deck_head;
    int unsigned                deck_left;
    int unsigned                deck_cursor;
    bit                         deck_shuffling;

    deck_result_t awaited_results [$];

    int send_idle_pct;
    int res_stall_pct;
    int hold_cycles;
    int fail_count;
    int items_sent;
    int useful_items;
    int ignored_items;
    int results_checked;
    int shuffles_done;
    int words_rejected;
    int cards_dealt;
    int stuck_cycles;

    shuffled_deal_store_unit #(
        .DECK_CARDS(DECK),
        .RANDOM_MAX(RMAX)
    ) u_top (.*);

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Put the expected deck back in order.
    function automatic void reset_deck();
        for (int k = 0; k < DECK; k++)
            deck_cards[k] = sds_pkg::CARD_W'(k);
        deck_head      = 0;
        deck_left      = DECK;
        deck_cursor    = 0;
        deck_shuffling = 1'b0;
    endfunction

    // Queue one expected result; remaining always reflects the deck after the item.
    function automatic void push_result(logic [sds_pkg::CARD_W-1:0] c, logic v, logic l,
                                        sds_pkg::status_t s, int unsigned dealt);
        deck_result_t r;
        r.card        = c;
        r.card_valid  = v;
        r.last        = l;
        r.status      = s;
        r.remaining   = sds_pkg::CNT_W'(deck_left);
        r.dealt_total = sds_pkg::CNT_W'(dealt);
        awaited_results.push_back(r);
        if (l && s == sds_pkg::ST_IGNORED)
            ignored_items++;
        else if (l)
            useful_items++;
    endfunction

    // Apply one accepted command to the expected deck and queue its results.
    task automatic predict_deck_item(input logic [sds_pkg::MODE_W-1:0] m,
                                     input logic [sds_pkg::WORD_W-1:0] w,
                                     input logic [sds_pkg::CNT_W-1:0] n);
        int unsigned                bound;
        int unsigned                lim;
        int unsigned                pick;
        int unsigned                pa;
        int unsigned                pb;
        int unsigned                actual;
        logic [sds_pkg::CARD_W-1:0] swap_card;
        logic [sds_pkg::CARD_W-1:0] hand [$];
        case (m)
            sds_pkg::MODE_REFILL:
            begin
                reset_deck();
                push_result('0, 1'b0, 1'b1, sds_pkg::ST_OK, 0);
            end
            sds_pkg::MODE_SHUFFLE:
            begin
                if (deck_shuffling)
                    push_result('0, 1'b0, 1'b1, sds_pkg::ST_IGNORED, 0);
                else if (deck_left <= 1)
                    push_result('0, 1'b0, 1'b1, sds_pkg::ST_FINISHED, 0);
                else
                begin
                    deck_cursor    = deck_left - 1;
                    deck_shuffling = 1'b1;
                    push_result('0, 1'b0, 1'b1, sds_pkg::ST_OK, 0);
                end
            end
            sds_pkg::MODE_WORD:
            begin
                if (!deck_shuffling)
                    push_result('0, 1'b0, 1'b1, sds_pkg::ST_IGNORED, 0);
                else
                begin
                    // Words in the biased tail of the range are thrown away.
                    bound = deck_cursor + 1;
                    lim   = RMAX - (RMAX % bound);
                    if (w >= lim)
                    begin
                        words_rejected++;
                        push_result('0, 1'b0, 1'b1, sds_pkg::ST_REJECTED, 0);
                    end
                    else
                    begin
                        pick = w % bound;
                        pa   = (deck_head + deck_cursor) % DECK;
                        pb   = (deck_head + pick) % DECK;
                        swap_card      = deck_cards[pa];
                        deck_cards[pa] = deck_cards[pb];
                        deck_cards[pb] = swap_card;
                        deck_cursor--;
                        if (deck_cursor == 0)
                        begin
                            deck_shuffling = 1'b0;
                            shuffles_done++;
                            push_result('0, 1'b0, 1'b1, sds_pkg::ST_FINISHED, 0);
                        end
                        else
                            push_result('0, 1'b0, 1'b1, sds_pkg::ST_OK, 0);
                    end
                end
            end
            default:
            begin
                if (deck_shuffling)
                    push_result('0, 1'b0, 1'b1, sds_pkg::ST_IGNORED, 0);
                else if (deck_left == 0)
                    push_result('0, 1'b0, 1'b1, sds_pkg::ST_EMPTY, 0);
                else
                begin
                    // Requests beyond the deck are cut to what remains.
                    actual = (n < deck_left) ? n : deck_left;
                    if (actual == 0)
                        push_result('0, 1'b0, 1'b1, sds_pkg::ST_OK, 0);
                    else
                    begin
                        for (int k = 0; k < actual; k++)
                            hand.push_back(deck_cards[(deck_head + k) % DECK]);
                        deck_head  = (deck_head + actual) % DECK;
                        deck_left -= actual;
                        cards_dealt += actual;
                        for (int k = 0; k < actual; k++)
                            push_result(hand[k], 1'b1, k == actual - 1, sds_pkg::ST_OK,
                                        actual);
                    end
                end
            end
        endcase
    endtask

    function automatic logic [sds_pkg::WORD_W-1:0] rand_word();
        return sds_pkg::WORD_W'($urandom_range(0, RMAX));
    endfunction

    function automatic logic [sds_pkg::CNT_W-1:0] rand_count();
        return sds_pkg::CNT_W'($urandom_range(0, 127));
    endfunction

    // Offer one command transaction and return at the edge that accepts it.
    task automatic send_item(input logic [sds_pkg::MODE_W-1:0] m,
                             input logic [sds_pkg::WORD_W-1:0] w,
                             input logic [sds_pkg::CNT_W-1:0] n);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid   <= 1'b1;
        mode        <= m;
        random_word <= w;
        deal_count  <= n;
        @(negedge clk);
        while (cmd_stall !== 1'b0)
            @(negedge clk);
        predict_deck_item(m, w, n);
        items_sent++;
        @(posedge clk);
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                res_stall <= 1'b1;
                hold_cycles--;
            end
            else
                res_stall <= ($urandom_range(0, 99) < res_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(negedge clk)
    begin : result_check
        deck_result_t got;
        deck_result_t want;
        if (rst_n && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            got.card        = card;
            got.card_valid  = card_valid;
            got.last        = last;
            got.status      = sds_pkg::status_t'(status);
            got.remaining   = remaining;
            got.dealt_total = dealt_total;
            results_checked++;
            if (awaited_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: card=%0d valid=%b last=%b status=%0d rem=%0d",
                             card, card_valid, last, status, remaining);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.card !== want.card || got.card_valid !== want.card_valid ||
                    got.last !== want.last || got.status !== want.status ||
                    got.remaining !== want.remaining || got.dealt_total !== want.dealt_total)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("mismatch: expected card=%0d valid=%b last=%b status=%0d rem=%0d dealt=%0d",
                                 want.card, want.card_valid, want.last, want.status,
                                 want.remaining, want.dealt_total);
                        $display("          got      card=%0d valid=%b last=%b status=%0d rem=%0d dealt=%0d",
                                 card, card_valid, last, status, remaining, dealt_total);
                    end
                end
            end
        end
    end

    // Watchdog: stop when neither channel moves for too long.
    initial
    begin
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(negedge clk);
            if ((cmd_valid === 1'b1 && cmd_stall === 1'b0) ||
                (res_valid === 1'b1 && res_stall === 1'b0))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // Directed corner cases: empty and saturated deals, ignored items, rejection,
    // abandoned shuffle, and shuffles over one and two cards.
    task automatic test_edge_cases();
        send_idle_pct = 0;
        res_stall_pct = 0;
        send_item(sds_pkg::MODE_DEAL, 15'h7FFF, 7'd0);
        send_item(sds_pkg::MODE_WORD, 15'h0000, 7'd0);
        send_item(sds_pkg::MODE_DEAL, 15'h5555, 7'd5);
        send_item(sds_pkg::MODE_SHUFFLE, 15'h2AAA, 7'd0);
        send_item(sds_pkg::MODE_SHUFFLE, 15'h0000, 7'd0);
        send_item(sds_pkg::MODE_DEAL, 15'h0000, 7'd3);
        send_item(sds_pkg::MODE_WORD, 15'h7FFF, 7'd0);
        send_item(sds_pkg::MODE_WORD, 15'h0000, 7'd0);
        send_item(sds_pkg::MODE_WORD, 15'h4000, 7'd0);
        send_item(sds_pkg::MODE_REFILL, 15'h0000, 7'd0);
        send_item(sds_pkg::MODE_DEAL, 15'h0000, 7'h7F);
        send_item(sds_pkg::MODE_DEAL, 15'h0000, 7'd1);
        send_item(sds_pkg::MODE_SHUFFLE, 15'h0000, 7'd0);
        send_item(sds_pkg::MODE_WORD, 15'h0001, 7'd0);
        send_item(sds_pkg::MODE_REFILL, 15'h0000, 7'd0);
        send_item(sds_pkg::MODE_DEAL, 15'h0000, 7'd50);
        send_item(sds_pkg::MODE_SHUFFLE, 15'h0000, 7'd0);
        send_item(sds_pkg::MODE_WORD, 15'h7FFF, 7'd0);
        send_item(sds_pkg::MODE_WORD, 15'h7FFE, 7'd0);
        send_item(sds_pkg::MODE_WORD, 15'h0001, 7'd0);
        send_item(sds_pkg::MODE_DEAL, 15'h0000, 7'd64);
        send_item(sds_pkg::MODE_REFILL, 15'h0000, 7'd0);
        send_item(sds_pkg::MODE_DEAL, 15'h0000, 7'd51);
        send_item(sds_pkg::MODE_SHUFFLE, 15'h0000, 7'd0);
        send_item(sds_pkg::MODE_DEAL, 15'h0000, 7'd3);
    endtask

    // Random rounds: thin the deck, shuffle it to the end, then deal it out.
    task automatic test_shuffle_rounds(input int idle_pct, input int stall_pct, input int quota);
        int                        first;
        int                        r;
        int                        keep;
        logic [sds_pkg::CNT_W-1:0] n;
        first         = useful_items;
        send_idle_pct = idle_pct;
        res_stall_pct = stall_pct;
        while (useful_items - first < quota)
        begin
            // Refill now and then, and always when too few cards remain to shuffle.
            if (deck_left < 2 || $urandom_range(0, 99) < 20)
                send_item(sds_pkg::MODE_REFILL, rand_word(), rand_count());
            // Most rounds deal most of the deck away so that shuffles stay short.
            if (deck_left > 12 && $urandom_range(0, 99) < 92)
            begin
                keep = $urandom_range(2, 12);
                send_item(sds_pkg::MODE_DEAL, rand_word(), sds_pkg::CNT_W'(deck_left - keep));
            end
            send_item(sds_pkg::MODE_SHUFFLE, rand_word(), rand_count());
            while (deck_shuffling)
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    send_item(r[0] ? sds_pkg::MODE_SHUFFLE : sds_pkg::MODE_DEAL, rand_word(),
                              rand_count());
                else if (r < 8)
                    send_item(sds_pkg::MODE_REFILL, rand_word(), rand_count());
                else if (r < 25)
                    send_item(sds_pkg::MODE_WORD,
                              sds_pkg::WORD_W'(RMAX - $urandom_range(0, 40)), rand_count());
                else
                    send_item(sds_pkg::MODE_WORD, rand_word(), rand_count());
            end
            // Deal out the shuffled cards, sometimes asking for far too many.
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 99) < 20)
                    n = rand_count();
                else
                    n = sds_pkg::CNT_W'($urandom_range(0, 6));
                send_item(sds_pkg::MODE_DEAL, rand_word(), n);
            end
        end
    endtask

    // Hold the result channel off while deals keep coming, so the input backs up.
    task automatic test_backpressure();
        send_idle_pct = 0;
        res_stall_pct = 0;
        send_item(sds_pkg::MODE_REFILL, rand_word(), rand_count());
        hold_cycles = 400;
        repeat (8)
            send_item(sds_pkg::MODE_DEAL, rand_word(), 7'd6);
        cmd_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Test sequence.
    initial
    begin
        rst_n           = 1'b0;
        cmd_valid       = 1'b0;
        mode            = sds_pkg::MODE_REFILL;
        random_word     = '0;
        deal_count      = '0;
        send_idle_pct   = 0;
        res_stall_pct   = 0;
        hold_cycles     = 0;
        fail_count      = 0;
        items_sent      = 0;
        useful_items    = 0;
        ignored_items   = 0;
        results_checked = 0;
        shuffles_done   = 0;
        words_rejected  = 0;
        cards_dealt     = 0;
        reset_deck();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_cases();
        test_shuffle_rounds(0, 0, 50);
        test_shuffle_rounds(57, 0, 50);
        test_shuffle_rounds(0, 57, 50);
        test_shuffle_rounds(18, 18, 50);
        test_backpressure();

        // Drain and give any stray result time to show up.
        res_stall_pct = 0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        $display("Sent %0d commands (%0d ignored), checked %0d results, dealt %0d cards.",
                 items_sent, ignored_items, results_checked, cards_dealt);
        $display("Finished %0d shuffles with %0d rejected words; %0d mismatches.",
                 shuffles_done, words_rejected, fail_count);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
